[src/mqsb_pkg.sv]
`timescale 1ns / 1ps

package mqsb_pkg;

    // store geometry
    localparam int NUM_SLOTS  = 64;
    localparam int NUM_QUEUES = 8;
    localparam int DATA_W     = 32;
    localparam int QID_W      = 3;
    localparam int STAT_W     = 2;
    localparam int SLOT_AW    = $clog2(NUM_SLOTS);
    localparam int PTR_W      = $clog2(NUM_SLOTS + 1);

    // pointer value that marks an empty list
    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(NUM_SLOTS);

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // data returned by a dequeue from an empty queue
    localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;

    // one write into the link store
    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] addr;
        logic [PTR_W-1:0]   data;
    } t_link_wr;

    // one write into the data store
    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] addr;
        logic [DATA_W-1:0]  data;
    } t_data_wr;

endpackage

[src/mqsb_req_if.sv]
`timescale 1ns / 1ps

interface mqsb_req_if import mqsb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [QID_W-1:0]         queue_id;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, output operation, output queue_id, output data_in,
                    input ready);
    modport sink   (input valid, input operation, input queue_id, input data_in,
                    output ready);
endinterface

[src/mqsb_rsp_if.sv]
`timescale 1ns / 1ps

interface mqsb_rsp_if import mqsb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output data_out, output status, input ready);
    modport sink   (input valid, input data_out, input status, output ready);
endinterface

[src/multi_queue_shared_buffer.sv]
`timescale 1ns / 1ps

// channel  | dir | words carry
// ---------+-----+----------------------------------------
// i_req    | in  | operation, queue_id, data_in
// o_rsp    | out | data_out, status
//
// an enqueue or dequeue that changes the lists first reads the link and data
// stores, then writes back the link and pointers
// a full enqueue or empty dequeue has no write-back step, nothing is stored
// reset clears pointers and link-store written flags at once, no clearing pass
// a new word is taken while the previous result sits in the output register;
// if that register is still full when a result is ready, input stalls until taken

module multi_queue_shared_buffer import mqsb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mqsb_req_if.sink          i_req,
    mqsb_rsp_if.source        o_rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WORK = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [PTR_W-1:0]         r_head [NUM_QUEUES];
    logic [PTR_W-1:0]         r_tail [NUM_QUEUES];
    logic [PTR_W-1:0]         r_free;
    logic                     r_op;
    logic [QID_W-1:0]         r_q;
    logic [PTR_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_res_data;
    logic [STAT_W-1:0]        r_res_status;
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_data;
    logic [STAT_W-1:0]        r_out_status;

    logic                     acc;
    logic [PTR_W-1:0]         head_q;
    logic [PTR_W-1:0]         idx;
    logic                     go;
    logic                     out_free;
    logic                     res_vld;
    logic signed [DATA_W-1:0] res_data;
    logic [STAT_W-1:0]        res_status;
    logic [PTR_W-1:0]         link_rd;
    logic [DATA_W-1:0]        data_rd;
    logic [PTR_W-1:0]         w_head;
    logic [PTR_W-1:0]         w_tail;
    t_link_wr                 link_wr;
    t_data_wr                 data_wr;

    assign i_req.ready = (r_state == ST_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign out_free    = !r_out_vld || o_rsp.ready;

    // accept cycle: pick the slot and check for full or empty
    assign head_q = r_head[i_req.queue_id];
    assign idx    = (i_req.operation == OP_ENQ) ? r_free : head_q;
    assign go     = (idx < PTR_NULL);

    // pointers of the queue under work
    assign w_head = r_head[r_q];
    assign w_tail = r_tail[r_q];

    // link writes: own slot when a word is accepted, old tail during write-back
    always_comb begin
        link_wr = '0;
        if (acc && go) begin
            link_wr.en   = 1'b1;
            link_wr.addr = idx[SLOT_AW-1:0];
            link_wr.data = (i_req.operation == OP_ENQ) ? PTR_NULL : r_free;
        end else if (r_state == ST_WORK && r_op == OP_ENQ &&
                     w_head < PTR_NULL && w_tail < PTR_NULL) begin
            link_wr.en   = 1'b1;
            link_wr.addr = w_tail[SLOT_AW-1:0];
            link_wr.data = r_idx;
        end
    end

    // data store write on enqueue
    always_comb begin
        data_wr      = '0;
        data_wr.en   = acc && go && (i_req.operation == OP_ENQ);
        data_wr.addr = idx[SLOT_AW-1:0];
        data_wr.data = i_req.data_in;
    end

    mqsb_link_mem u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (idx[SLOT_AW-1:0]),
        .o_rd_data (link_rd),
        .i_wr      (link_wr)
    );

    mqsb_data_mem u_data (
        .i_clk     (i_clk),
        .i_rd_addr (idx[SLOT_AW-1:0]),
        .o_rd_data (data_rd),
        .i_wr      (data_wr)
    );

    // result of this cycle, if any
    always_comb begin
        res_vld    = 1'b0;
        res_data   = '0;
        res_status = STAT_OK;
        if (acc && !go) begin
            res_vld = 1'b1;
            if (i_req.operation == OP_ENQ) begin
                res_status = STAT_FULL;
            end else begin
                res_data   = EMPTY_DATA;
                res_status = STAT_EMPTY;
            end
        end else if (r_state == ST_WORK) begin
            res_vld = 1'b1;
            if (r_op == OP_DEQ) begin
                res_data = data_rd;
            end
        end
    end

    // control sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (go) begin
                        n_state = ST_WORK;
                    end else if (!out_free) begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_WORK: n_state = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD: n_state = out_free ? ST_IDLE : ST_HOLD;
            default: n_state = ST_IDLE;
        endcase
    end

    // state, list pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_free    <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= PTR_NULL;
                r_tail[i] <= PTR_NULL;
            end
        end else begin
            r_state <= n_state;
            // write-back state: pointer write-back
            if (r_state == ST_WORK) begin
                if (r_op == OP_ENQ) begin
                    r_free     <= link_rd;
                    r_tail[r_q] <= r_idx;
                    if (!(w_head < PTR_NULL)) begin
                        r_head[r_q] <= r_idx;
                    end
                end else begin
                    r_head[r_q] <= link_rd;
                    r_free      <= r_idx;
                end
            end
            // output register
            if (r_state == ST_HOLD && out_free) begin
                r_out_vld <= 1'b1;
            end else if (res_vld && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // word capture and result payloads
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= i_req.operation;
            r_q   <= i_req.queue_id;
            r_idx <= idx;
        end
        if (res_vld && !out_free) begin
            r_res_data   <= res_data;
            r_res_status <= res_status;
        end
        if (r_state == ST_HOLD && out_free) begin
            r_out_data   <= r_res_data;
            r_out_status <= r_res_status;
        end else if (res_vld && out_free) begin
            r_out_data   <= res_data;
            r_out_status <= res_status;
        end
    end

    assign o_rsp.valid    = r_out_vld;
    assign o_rsp.data_out = r_out_data;
    assign o_rsp.status   = r_out_status;

    // the write-back state is never entered twice in a row
    a_work_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WORK |=> r_state != ST_WORK)
        else $error("write-back cycle repeated");

    // a held result only exists while the output register is occupied
    a_hold_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HOLD |-> r_out_vld)
        else $error("result held with output register empty");

    // an enqueue under write-back always owns a real slot
    a_enq_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WORK && r_op == OP_ENQ) |-> (r_idx < PTR_NULL))
        else $error("enqueue working on null slot");

    // entering write-back follows an accepted word
    a_work_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_WORK) |-> $past(acc))
        else $error("write-back without accepted word");

endmodule

[src/mqsb_link_mem.sv]
`timescale 1ns / 1ps

module mqsb_link_mem import mqsb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SLOT_AW-1:0] i_rd_addr,
    output logic [PTR_W-1:0]   o_rd_data,
    input  t_link_wr           i_wr
);

    logic [PTR_W-1:0]   r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;
    logic [PTR_W-1:0]   r_rd_raw;
    logic               r_rd_vld;
    logic [SLOT_AW-1:0] r_rd_addr;

    // link array, read-first
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_raw  <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    // written flags, an unwritten slot links to the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    // last slot plus one is the null pointer
    assign o_rd_data = r_rd_vld ? r_rd_raw : (PTR_W'(r_rd_addr) + PTR_W'(1));

endmodule

[src/mqsb_data_mem.sv]
`timescale 1ns / 1ps

module mqsb_data_mem import mqsb_pkg::*; (
    input  logic               i_clk,
    input  logic [SLOT_AW-1:0] i_rd_addr,
    output logic [DATA_W-1:0]  o_rd_data,
    input  t_data_wr           i_wr
);

    logic [DATA_W-1:0] r_mem [NUM_SLOTS];
    logic [DATA_W-1:0] r_rd_data;

    // data array, read-first
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[verif/tb_multi_queue_shared_buffer.sv]
`timescale 1ns / 1ps

module tb_multi_queue_shared_buffer import mqsb_pkg::*; ();

    localparam int CYCLE_LIMIT = 200000;

    // one expected response word
    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        status;
    } t_dq_result;

    logic i_clk;
    logic i_rst_n;

    mqsb_req_if req_ch ();
    mqsb_rsp_if rsp_ch ();

    multi_queue_shared_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // shadow copy of the linked lists
    logic [PTR_W-1:0]  shadow_head [NUM_QUEUES];
    logic [PTR_W-1:0]  shadow_tail [NUM_QUEUES];
    logic [PTR_W-1:0]  shadow_link [NUM_SLOTS];
    logic [DATA_W-1:0] shadow_data [NUM_SLOTS];
    logic [PTR_W-1:0]  shadow_free;

    t_dq_result pending_results[$];
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         stall_left     = 0;
    bit         idle_off       = 1'b0;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_multi_queue_shared_buffer: done, errors");
            $finish;
        end
    end

    // lists after reset: every slot chained into the free list
    function automatic void clear_shadow();
        for (int i = 0; i < NUM_QUEUES; i++) begin
            shadow_head[i] = PTR_NULL;
            shadow_tail[i] = PTR_NULL;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            shadow_link[i] = PTR_W'(i + 1);
            shadow_data[i] = '0;
        end
        shadow_link[NUM_SLOTS-1] = PTR_NULL;
        shadow_free = '0;
    endfunction

    // apply one queue operation to the shadow lists, return the response
    function automatic t_dq_result apply_queue_op(input logic op,
                                                  input logic [QID_W-1:0] qid,
                                                  input logic signed [DATA_W-1:0] din);
        t_dq_result         res;
        logic [PTR_W-1:0]   slot;
        logic [SLOT_AW-1:0] addr;
        logic [SLOT_AW-1:0] tail_addr;
        if (op == OP_ENQ) begin
            res.data = '0;
            if (shadow_free == PTR_NULL) begin
                res.status = STAT_FULL;
            end else begin
                slot        = shadow_free;
                addr        = slot[SLOT_AW-1:0];
                shadow_free = shadow_link[addr];
                if (shadow_head[qid] == PTR_NULL) begin
                    shadow_head[qid] = slot;
                end else begin
                    tail_addr              = shadow_tail[qid][SLOT_AW-1:0];
                    shadow_link[tail_addr] = slot;
                end
                shadow_link[addr] = PTR_NULL;
                shadow_tail[qid]  = slot;
                shadow_data[addr] = din;
                res.status        = STAT_OK;
            end
        end else begin
            if (shadow_head[qid] == PTR_NULL) begin
                res.data   = EMPTY_DATA;
                res.status = STAT_EMPTY;
            end else begin
                slot              = shadow_head[qid];
                addr              = slot[SLOT_AW-1:0];
                shadow_head[qid]  = shadow_link[addr];
                shadow_link[addr] = shadow_free;
                shadow_free       = slot;
                res.data          = shadow_data[addr];
                res.status        = STAT_OK;
            end
        end
        return res;
    endfunction

    // drive one request word, optionally after an idle burst
    task automatic send_word(input logic op, input logic [QID_W-1:0] qid,
                             input logic signed [DATA_W-1:0] din);
        int gap;
        @(negedge i_clk);
        if (!idle_off && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.queue_id  <= qid;
        req_ch.data_in   <= din;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(apply_queue_op(op, qid, din));
    endtask

    // random word; enqueue share in percent, queues 0 and 1 favored for long chains
    task automatic send_random(input int enq_pct);
        logic                     op;
        logic [QID_W-1:0]         qid;
        logic signed [DATA_W-1:0] din;
        op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        qid = ($urandom_range(0, 3) == 0) ? QID_W'($urandom_range(0, 1))
                                          : QID_W'($urandom_range(0, NUM_QUEUES - 1));
        case ($urandom_range(0, 15))
            0:       din = 32'h7fff_ffff;
            1:       din = 32'h8000_0000;
            2:       din = '1;
            3:       din = '0;
            default: din = $urandom;
        endcase
        send_word(op, qid, din);
    endtask

    // response stalls in random bursts, none while idling is off
    always @(negedge i_clk) begin
        if (idle_off) begin
            rsp_ch.ready <= 1'b1;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 8);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // compare each response word with the oldest expectation
    always @(posedge i_clk) begin
        t_dq_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected response: data_out %0d status %0d",
                       rsp_ch.data_out, rsp_ch.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.data_out !== want.data) begin
                    $error("data_out: expected %0d, actual %0d", want.data, rsp_ch.data_out);
                    mismatch_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    // empty dequeues, data extremes, both ends of the queue range
    task automatic test_directed_edges();
        send_word(OP_DEQ, 3'd0, '0);
        send_word(OP_DEQ, 3'd7, 32'h7fff_ffff);
        send_word(OP_ENQ, 3'd0, 32'h7fff_ffff);
        send_word(OP_ENQ, 3'd0, 32'h8000_0000);
        send_word(OP_ENQ, 3'd0, '0);
        send_word(OP_ENQ, 3'd0, '1);
        send_word(OP_ENQ, 3'd7, 32'h5555_aaaa);
        send_word(OP_DEQ, 3'd0, '1);
        send_word(OP_DEQ, 3'd7, '0);
        send_word(OP_DEQ, 3'd0, '0);
        send_word(OP_DEQ, 3'd0, '0);
        send_word(OP_DEQ, 3'd0, '0);
        send_word(OP_DEQ, 3'd0, '0);
        send_word(OP_DEQ, 3'd7, '0);
    endtask

    // enqueue-heavy: fills the store and overflows it
    task automatic test_fill_and_overflow();
        for (int i = 0; i < 160; i++) send_random(85);
    endtask

    // dequeue-heavy: drains the lists, returns slots to the free list
    task automatic test_drain();
        for (int i = 0; i < 160; i++) send_random(15);
    endtask

    // balanced traffic, free list order gets scrambled
    task automatic test_mixed();
        for (int i = 0; i < 380; i++) send_random(($urandom_range(0, 1) == 0) ? 60 : 45);
    endtask

    // back-to-back words with no idling on either side
    task automatic test_full_rate();
        idle_off = 1'b1;
        for (int i = 0; i < 140; i++) send_random(55);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_ENQ;
        req_ch.queue_id  = '0;
        req_ch.data_in   = '0;
        rsp_ch.ready     = 1'b0;
        clear_shadow();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_fill_and_overflow();
        test_drain();
        test_mixed();
        test_full_rate();

        // drain outstanding responses
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_multi_queue_shared_buffer: done, clean");
        end else begin
            $display("tb_multi_queue_shared_buffer: done, errors");
        end
        $finish;
    end

endmodule
